### rtl/gcode_line_tokenizer_dispatch_assert.svh
// Assertion macros used by the checker file of the G-code tokenizer.
`ifndef GCODE_LINE_TOKENIZER_DISPATCH_ASSERT_SVH
`define GCODE_LINE_TOKENIZER_DISPATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gltd_pkg.sv
// Shared types and constants of the G-code line tokenizer and dispatcher.
package gltd_pkg;

  localparam int MAX_TOKEN_CHARS = 14;
  localparam int MAX_TOKENS      = 5;

  localparam int TOK_W = $clog2(MAX_TOKENS);
  localparam int CHR_W = $clog2(MAX_TOKEN_CHARS + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] STEPS_TENTHS_RESET = 16'd2267;
  localparam logic [15:0] STEP_PERIOD_RESET  = 16'd1200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS  = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_NOT_IMPL = 2'd2
  } status_e;

  // What the back end has to do for one dispatched line or error.
  typedef enum logic [2:0] {
    OP_ONE,     // a single status result
    OP_PAIR,    // a status result, then ok
    OP_REPORT,  // a limit switch report, then ok
    OP_MOVE,    // an X move request, then ok
    OP_TOGGLE   // flip the direction flag, no result
  } op_e;

  // States of the dispatch back end.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIRST,
    BK_SECOND
  } bk_state_e;

  typedef struct packed {
    op_e         op;
    status_e     status;
    logic        mn;
    logic        mx;
    logic [15:0] number;
  } cmd_t;

endpackage

### rtl/gltd_if.sv
// Valid/ready channel interfaces for command bytes and result beats.
interface gltd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       min_limit;
  logic       max_limit;

  modport source (output valid, rx_byte, min_limit, max_limit, input ready);
  modport sink (input valid, rx_byte, min_limit, max_limit, output ready);
  modport monitor (input valid, ready, rx_byte, min_limit, max_limit);
endinterface

interface gltd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [28:0] step_count;
  logic [15:0] step_period;
  logic        dir_level;
  logic        min_level;
  logic        max_level;
  logic        last;

  modport source (output valid, kind, status, step_count, step_period, dir_level,
                  min_level, max_level, last, input ready);
  modport sink (input valid, kind, status, step_count, step_period, dir_level,
                min_level, max_level, last, output ready);
  modport monitor (input valid, ready, kind, status, step_count, step_period, dir_level,
                   min_level, max_level, last);
endinterface

### rtl/gltd_fifo.sv
// Small command queue between the tokenizer front end and the dispatch back end.
module gltd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gltd_pkg::cmd_t data_i,
  input  logic           pop_i,
  output gltd_pkg::cmd_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import gltd_pkg::*;

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/gltd_front.sv
// Tokenizer front end: splits bytes into tokens and classifies each line.
module gltd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  gltd_in_if.sink        rx,
  input  logic           q_full_i,
  output logic           push_o,
  output gltd_pkg::cmd_t cmd_o
);
  import gltd_pkg::*;

  localparam logic [7:0] ASCII_LF = 8'd10;
  localparam logic [7:0] ASCII_SP = 8'd32;
  localparam logic [7:0] ASCII_0  = 8'd48;
  localparam logic [7:0] ASCII_9  = 8'd57;
  localparam logic [7:0] ASCII_LA = 8'd97;
  localparam logic [7:0] ASCII_LZ = 8'd122;
  localparam logic [7:0] CHR_G    = 8'd71;
  localparam logic [7:0] CHR_M    = 8'd77;
  localparam logic [7:0] CHR_X    = 8'd88;
  localparam logic [7:0] CHR_Y    = 8'd89;
  localparam logic [7:0] CHR_Z    = 8'd90;
  localparam logic [15:0] NUM_MAX  = 16'd65535;
  localparam logic [15:0] CODE_0   = 16'd0;
  localparam logic [15:0] CODE_1   = 16'd1;
  localparam logic [15:0] CODE_2   = 16'd2;
  localparam logic [15:0] CODE_3   = 16'd3;
  localparam logic [15:0] CODE_4   = 16'd4;
  localparam logic [15:0] CODE_28  = 16'd28;

  localparam cmd_t CMD_UNKNOWN = '{op: OP_ONE, status: ST_UNKNOWN, mn: 1'b0, mx: 1'b0,
                                   number: 16'd0};

  logic [TOK_W-1:0] tok_q, tok_d;
  logic [CHR_W-1:0] chr_q, chr_d;
  logic [7:0]       code_letter_q, code_letter_d;
  logic [15:0]      code_num_q, code_num_d;
  logic             code_done_q, code_done_d;
  logic [7:0]       axis_letter_q, axis_letter_d;
  logic [15:0]      axis_num_q, axis_num_d;
  logic             axis_done_q, axis_done_d;
  logic             fire;
  logic             line_clear;

  // Returns {done, number} after one more character of a token.
  function automatic logic [16:0] add_digit(logic [15:0] num, logic done, logic [7:0] c);
    logic [19:0] v;
    logic [16:0] r;
    r = {done, num};
    v = ({4'b0, num} * 20'd10) + {16'b0, c[3:0]};
    if (!done) begin
      if (c >= ASCII_0 && c <= ASCII_9) begin
        r = {1'b0, (v > {4'b0, NUM_MAX}) ? NUM_MAX : v[15:0]};
      end else begin
        r = {1'b1, num};
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= ASCII_LA && c <= ASCII_LZ) ? c - 8'd32 : c;
  endfunction

  function automatic cmd_t classify(logic [7:0] letter, logic [15:0] code,
                                    logic [7:0] axis, logic [15:0] axis_num,
                                    logic mn, logic mx);
    cmd_t       c;
    logic [7:0] l;
    logic [7:0] a;
    c = CMD_UNKNOWN;
    l = to_upper(letter);
    a = to_upper(axis);
    if (l == CHR_M) begin
      if (code == CODE_1) begin
        c.op = OP_REPORT;
        c.mn = mn;
        c.mx = mx;
      end else if (code != CODE_0) begin
        c.op = OP_PAIR;
      end else begin
        c.status = ST_OK;
      end
    end else if (l == CHR_G) begin
      if (code == CODE_0) begin
        if (a == CHR_X) begin
          c.op     = OP_MOVE;
          c.number = axis_num;
        end else if (a == CHR_Y || a == CHR_Z) begin
          c.status = ST_OK;
        end else begin
          c.op = OP_PAIR;
        end
      end else if (code == CODE_1 || code == CODE_2 || code == CODE_3 || code == CODE_28) begin
        c.status = ST_NOT_IMPL;
      end else if (code == CODE_4) begin
        c.op = OP_TOGGLE;
      end
    end
    return c;
  endfunction

  // Every byte may push one command, so a full queue holds off the sender.
  assign rx.ready = !q_full_i;
  assign fire     = rx.valid && rx.ready;

  always_comb begin
    tok_d         = tok_q;
    chr_d         = chr_q;
    code_letter_d = code_letter_q;
    code_num_d    = code_num_q;
    code_done_d   = code_done_q;
    axis_letter_d = axis_letter_q;
    axis_num_d    = axis_num_q;
    axis_done_d   = axis_done_q;
    push_o        = 1'b0;
    cmd_o         = CMD_UNKNOWN;
    line_clear    = 1'b0;
    if (fire) begin
      if (rx.rx_byte == ASCII_LF) begin
        push_o     = 1'b1;
        cmd_o      = classify(code_letter_q, code_num_q, axis_letter_q, axis_num_q,
                              rx.min_limit, rx.max_limit);
        line_clear = 1'b1;
      end else if (rx.rx_byte == ASCII_SP) begin
        if (({1'b0, tok_q} + 1'b1) >= (TOK_W + 1)'(MAX_TOKENS)) begin
          push_o     = 1'b1;
          line_clear = 1'b1;
        end else begin
          tok_d = tok_q + 1'b1;
          chr_d = '0;
        end
      end else begin
        if (chr_q >= CHR_W'(MAX_TOKEN_CHARS)) begin
          push_o     = 1'b1;
          line_clear = 1'b1;
        end else begin
          if (tok_q == '0) begin
            if (chr_q == '0) begin
              code_letter_d = rx.rx_byte;
            end else begin
              {code_done_d, code_num_d} = add_digit(code_num_q, code_done_q, rx.rx_byte);
            end
          end else if (tok_q == TOK_W'(1)) begin
            if (chr_q == '0) begin
              axis_letter_d = rx.rx_byte;
            end else begin
              {axis_done_d, axis_num_d} = add_digit(axis_num_q, axis_done_q, rx.rx_byte);
            end
          end
          chr_d = chr_q + 1'b1;
        end
      end
      if (line_clear) begin
        tok_d         = '0;
        chr_d         = '0;
        code_letter_d = '0;
        code_num_d    = '0;
        code_done_d   = 1'b0;
        axis_letter_d = '0;
        axis_num_d    = '0;
        axis_done_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q         <= '0;
      chr_q         <= '0;
      code_letter_q <= '0;
      code_num_q    <= '0;
      code_done_q   <= 1'b0;
      axis_letter_q <= '0;
      axis_num_q    <= '0;
      axis_done_q   <= 1'b0;
    end else begin
      tok_q         <= tok_d;
      chr_q         <= chr_d;
      code_letter_q <= code_letter_d;
      code_num_q    <= code_num_d;
      code_done_q   <= code_done_d;
      axis_letter_q <= axis_letter_d;
      axis_num_q    <= axis_num_d;
      axis_done_q   <= axis_done_d;
    end
  end

endmodule

### rtl/gltd_back.sv
// Dispatch back end: turns queued commands into result beats.
module gltd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  gltd_pkg::cmd_t q_head_i,
  output logic           pop_o,
  input  logic [15:0]    steps_tenths_i,
  input  logic [15:0]    step_period_i,
  gltd_out_if.source     res
);
  import gltd_pkg::*;

  // ceil(2^35 / 10): floor(p / 10) == (p * RECIP_10) >> 35 for any 32-bit p.
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

  bk_state_e   state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic        dir_q, dir_d;
  logic [31:0] prod_q;
  logic [28:0] steps_q;
  logic [63:0] quot_full;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        load;
  kind_e       kind_q, kind_d;
  status_e     status_q, status_d;
  logic [28:0] count_q, count_d;
  logic [15:0] period_q, period_d;
  logic        dlev_q, dlev_d;
  logic        mn_q, mn_d;
  logic        mx_q, mx_d;
  logic        last_q, last_d;

  assign out_free  = !out_valid_q || res.ready;
  assign quot_full = 64'(prod_q) * 64'(RECIP_10);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    dir_d    = dir_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    kind_d   = KIND_STATUS;
    status_d = ST_OK;
    count_d  = '0;
    period_d = '0;
    mn_d     = 1'b0;
    mx_d     = 1'b0;
    last_d   = 1'b1;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          cmd_d = q_head_i;
          case (q_head_i.op)
            OP_TOGGLE: dir_d   = ~dir_q;
            OP_MOVE:   state_d = BK_MUL;
            default:   state_d = BK_FIRST;
          endcase
        end
      end
      BK_MUL: state_d = BK_DIV;
      BK_DIV: state_d = BK_FIRST;
      BK_FIRST: begin
        if (out_free) begin
          load   = 1'b1;
          last_d = (cmd_q.op == OP_ONE);
          case (cmd_q.op)
            OP_REPORT: begin
              kind_d = KIND_REPORT;
              mn_d   = cmd_q.mn;
              mx_d   = cmd_q.mx;
            end
            OP_MOVE: begin
              kind_d   = KIND_MOVE;
              count_d  = steps_q;
              period_d = step_period_i;
            end
            default: status_d = cmd_q.status;
          endcase
          state_d = (cmd_q.op == OP_ONE) ? BK_IDLE : BK_SECOND;
        end
      end
      BK_SECOND: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign dlev_d = dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      dir_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (state_q == BK_MUL) begin
      prod_q <= 32'(cmd_q.number) * 32'(steps_tenths_i);
    end
    if (state_q == BK_DIV) begin
      steps_q <= quot_full[63:35];
    end
    if (load) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      count_q  <= count_d;
      period_q <= period_d;
      dlev_q   <= dlev_d;
      mn_q     <= mn_d;
      mx_q     <= mx_d;
      last_q   <= last_d;
    end
  end

  assign res.valid       = out_valid_q;
  assign res.kind        = kind_q;
  assign res.status      = status_q;
  assign res.step_count  = count_q;
  assign res.step_period = period_q;
  assign res.dir_level   = dlev_q;
  assign res.min_level   = mn_q;
  assign res.max_level   = mx_q;
  assign res.last        = last_q;

endmodule

### rtl/gcode_line_tokenizer_dispatch.sv
// Top level of the G-code line tokenizer and dispatcher.
// Throughput: one byte beat per cycle while the four-entry command queue has room.
// Results of a line pass through the command queue, the back-end state register and
//   the output register; a move request also passes the registered multiply and
//   reciprocal divide in the back end. The back end takes a new command only from idle,
//   and the second result is loaded once the output register is free.
// Reset (rst_ni low, asynchronous) clears the line state, empties the queue, sets the
//   direction flag and loads the configuration registers with their defaults.
module gcode_line_tokenizer_dispatch (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gltd_in_if.sink                        rx_i,
  gltd_out_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [gltd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gltd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gltd_pkg::*;

  // Configuration registers. The user must write them only while the block is idle; the
  // block does not enforce this. The back end reads them directly without any shadowing.
  logic [15:0] steps_tenths_q, steps_tenths_d;
  logic [15:0] step_period_q, step_period_d;

  // Command queue between the front and back ends.
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  always_comb begin
    steps_tenths_d = steps_tenths_q;
    step_period_d  = step_period_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEPS:  steps_tenths_d = cfg_data_i;
        CFG_PERIOD: step_period_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_tenths_q <= STEPS_TENTHS_RESET;
      step_period_q  <= STEP_PERIOD_RESET;
    end else begin
      steps_tenths_q <= steps_tenths_d;
      step_period_q  <= step_period_d;
    end
  end

  // The front end consumes a byte beat in the cycle it arrives whenever the
  // queue has room. It only pushes a command at a newline or when a line
  // overflows, but it holds off every byte while the queue is full.
  gltd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx       (rx_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  gltd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back end pops one command at a time, owns the direction flag so that
  // toggles stay in line order with the results, and drives an output
  // register that lets it prepare the next command while the last result beat is stalled.
  gltd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (head_cmd),
    .pop_o          (pop),
    .steps_tenths_i (steps_tenths_q),
    .step_period_i  (step_period_q),
    .res            (res_o)
  );

endmodule

### rtl/gltd_checker.sv
// Port-level assertions on the result channel of the tokenizer, bound to the top level.
`include "gcode_line_tokenizer_dispatch_assert.svh"

module gltd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  gltd_out_if.source res
);
  import gltd_pkg::*;

  `GLTD_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, res.valid && !res.ready, res.valid && $stable(res.kind) && $stable(res.status) && $stable(res.step_count) && $stable(res.last), "stalled result beat changed")
  `GLTD_ASSERT_IMP(a_two_part_not_last, clk_i, rst_ni, res.valid && (res.kind == KIND_MOVE || res.kind == KIND_REPORT), !res.last, "move or report beat marked last")
  `GLTD_ASSERT_IMP(a_move_fields_only, clk_i, rst_ni, res.valid && res.kind != KIND_MOVE, res.step_count == '0 && res.step_period == '0, "move fields set outside a move")
  `GLTD_ASSERT_IMP(a_report_fields_only, clk_i, rst_ni, res.valid && res.kind != KIND_REPORT, !res.min_level && !res.max_level, "switch levels set outside a report")

endmodule

bind gcode_line_tokenizer_dispatch gltd_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .res    (res_o)
);
